// ===== hw/rtl/pfvs_pkg.sv =====
// Package for the page frame victim selector.
// Holds the field widths, item and status codes, and the cell record and command types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pfvs_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned TAG_W   = 20;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_VICTIM  = 2'd0,
    KIND_MAP     = 2'd1,
    KIND_ACCESS  = 2'd2,
    KIND_PROTECT = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_FREE  = 2'd0,
    STAT_CLEAN = 2'd1,
    STAT_DIRTY = 2'd2,
    STAT_NONE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_MAP     = 3'd1,
    OP_ACCESS  = 3'd2,
    OP_PROTECT = 3'd3,
    OP_EVICT   = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic prot;
    logic mapped;
    logic refd;
    logic dirty;
  } rec_t;

  typedef struct packed {
    logic     shift;
    logic     we;
    cell_op_e op;
    logic     wr_access;
    logic     protect;
  } cell_cmd_t;

  typedef struct packed {
    logic               ready;
    logic               shift;
    logic               clr_ref;
    logic               evict;
    logic               done;
    logic [FRAME_W-1:0] frame;
    status_e            status;
    logic               use_mem;
  } scan_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfvs_if.sv =====
// Request and result channel interfaces of the page frame victim selector.
// Each carries valid, ready and the payload fields; depends on pfvs_pkg.
`default_nettype none

interface pfvs_req_if;
  logic                          valid;
  logic                          ready;
  logic [pfvs_pkg::KIND_W-1:0]   kind;
  logic [pfvs_pkg::FRAME_W-1:0]  frame_index;
  logic [pfvs_pkg::TAG_W-1:0]    page_tag;
  logic [pfvs_pkg::OWNER_W-1:0]  owner_id;
  logic                          write_access;
  logic                          protect_flag;

  modport source (
    output valid, kind, frame_index, page_tag, owner_id, write_access, protect_flag,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_index, page_tag, owner_id, write_access, protect_flag,
    output ready
  );
endinterface

interface pfvs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pfvs_pkg::FRAME_W-1:0]  victim_frame;
  logic [pfvs_pkg::STAT_W-1:0]   status;
  logic [pfvs_pkg::TAG_W-1:0]    evicted_tag;
  logic [pfvs_pkg::OWNER_W-1:0]  evicted_owner;

  modport source (
    output valid, victim_frame, status, evicted_tag, evicted_owner,
    input  ready
  );
  modport sink (
    input  valid, victim_frame, status, evicted_tag, evicted_owner,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/pfvs_cell.sv =====
// One frame cell of the rotating frame ring: protected, mapped, referenced and dirty bits.
// Shifts its record to the neighbour during a scan, otherwise takes addressed updates.
// Depends on pfvs_pkg.
`default_nettype none

module pfvs_cell #(
  parameter int unsigned IDX_W = 8,
  parameter int unsigned IDX   = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  pfvs_pkg::cell_cmd_t    cmd_i,
  input  wire        [IDX_W-1:0] idx_i,
  input  pfvs_pkg::rec_t         nb_i,
  output pfvs_pkg::rec_t         rec_o
);

  pfvs_pkg::rec_t rec_q, rec_d;
  logic           hit;

  assign hit = cmd_i.we && (idx_i == IDX_W'(IDX));

  always_comb begin
    rec_d = rec_q;
    if (cmd_i.shift) begin
      rec_d = nb_i;
    end else if (hit) begin
      case (cmd_i.op)
        pfvs_pkg::OP_MAP: begin
          rec_d.mapped = 1'b1;
          rec_d.refd   = 1'b1;
          rec_d.dirty  = 1'b0;
        end
        pfvs_pkg::OP_ACCESS: begin
          if (rec_q.mapped) begin
            rec_d.refd  = 1'b1;
            rec_d.dirty = rec_q.dirty | cmd_i.wr_access;
          end
        end
        pfvs_pkg::OP_PROTECT: begin
          rec_d.prot = cmd_i.protect;
        end
        pfvs_pkg::OP_EVICT: begin
          rec_d.mapped = 1'b0;
          rec_d.refd   = 1'b0;
          rec_d.dirty  = 1'b0;
        end
        default: begin
          rec_d = rec_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfvs_scan.sv =====
// Victim search sequencer: steps the frame ring past the head cell and keeps the candidates.
// Holds both policy hands and the result of the current victim request.
// Depends on pfvs_pkg.
`default_nettype none

module pfvs_scan #(
  parameter int unsigned FRAME_COUNT = 256,
  localparam int unsigned FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire                      mode_i,
  input  pfvs_pkg::rec_t           head_i,
  input  wire                      out_free_i,
  output pfvs_pkg::scan_out_t      ctl_o,
  output logic            [FW-1:0] victim_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PASS1  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_PASS2  = 3'd3;
  localparam logic [2:0] ST_EVICT  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [FW-1:0] LAST = FW'(FRAME_COUNT - 1);

  logic [2:0]    state_q, state_d;
  logic [FW-1:0] t_q, t_d;
  logic [FW-1:0] hand_q, hand_d;
  logic [FW-1:0] fifo_hand_q, fifo_hand_d;
  logic [FW-1:0] clock_hand_q, clock_hand_d;
  logic          mode_q, mode_d;
  logic          clear_all_q, clear_all_d;
  logic [FW-1:0] vic_q, vic_d;

  logic          fr_f_q, fr_f_d;
  logic [FW-1:0] fr_idx_q, fr_idx_d;
  logic          ua_f_q, ua_f_d, ub_f_q, ub_f_d, ra_f_q, ra_f_d, rb_f_q, rb_f_d;
  logic [FW-1:0] ua_idx_q, ua_idx_d, ub_idx_q, ub_idx_d;
  logic [FW-1:0] ra_idx_q, ra_idx_d, rb_idx_q, rb_idx_d;
  logic          ua_dt_q, ua_dt_d, ub_dt_q, ub_dt_d, ra_dt_q, ra_dt_d, rb_dt_q, rb_dt_d;

  logic [pfvs_pkg::FRAME_W-1:0] res_frame_q, res_frame_d;
  pfvs_pkg::status_e            res_stat_q, res_stat_d;
  logic                         res_mem_q, res_mem_d;

  logic          last, after, unprot, unref, free, in_rng, use_r;
  logic [FW-1:0] pick_idx, next_vic;
  logic          pick_dt;

  assign last   = (t_q == LAST);
  assign after  = (t_q >= hand_q);
  assign unprot = !head_i.prot;
  assign unref  = unprot && !head_i.refd;
  assign free   = unprot && !head_i.mapped;
  assign in_rng = (vic_q >= hand_q) ? (after && (t_q < vic_q)) : (after || (t_q < vic_q));
  assign use_r  = mode_q && (ra_f_q || rb_f_q);
  assign next_vic = (vic_q == LAST) ? '0 : vic_q + FW'(1);

  always_comb begin
    if (use_r) begin
      pick_idx = ra_f_q ? ra_idx_q : rb_idx_q;
      pick_dt  = ra_f_q ? ra_dt_q : rb_dt_q;
    end else begin
      pick_idx = ua_f_q ? ua_idx_q : ub_idx_q;
      pick_dt  = ua_f_q ? ua_dt_q : ub_dt_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    t_d          = t_q;
    hand_d       = hand_q;
    fifo_hand_d  = fifo_hand_q;
    clock_hand_d = clock_hand_q;
    mode_d       = mode_q;
    clear_all_d  = clear_all_q;
    vic_d        = vic_q;
    fr_f_d = fr_f_q; fr_idx_d = fr_idx_q;
    ua_f_d = ua_f_q; ua_idx_d = ua_idx_q; ua_dt_d = ua_dt_q;
    ub_f_d = ub_f_q; ub_idx_d = ub_idx_q; ub_dt_d = ub_dt_q;
    ra_f_d = ra_f_q; ra_idx_d = ra_idx_q; ra_dt_d = ra_dt_q;
    rb_f_d = rb_f_q; rb_idx_d = rb_idx_q; rb_dt_d = rb_dt_q;
    res_frame_d = res_frame_q;
    res_stat_d  = res_stat_q;
    res_mem_d   = res_mem_q;
    ctl_o         = '0;
    ctl_o.ready   = (state_q == ST_IDLE);
    ctl_o.frame   = res_frame_q;
    ctl_o.status  = res_stat_q;
    ctl_o.use_mem = res_mem_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          hand_d = mode_i ? clock_hand_q : fifo_hand_q;
          mode_d = mode_i;
          t_d    = '0;
          fr_f_d = 1'b0;
          ua_f_d = 1'b0;
          ub_f_d = 1'b0;
          ra_f_d = 1'b0;
          rb_f_d = 1'b0;
          state_d = ST_PASS1;
        end
      end
      ST_PASS1: begin
        ctl_o.shift = 1'b1;
        if (free && !fr_f_q) begin
          fr_f_d = 1'b1; fr_idx_d = t_q;
        end
        if (unprot && after && !ua_f_q) begin
          ua_f_d = 1'b1; ua_idx_d = t_q; ua_dt_d = head_i.dirty;
        end
        if (unprot && !after && !ub_f_q) begin
          ub_f_d = 1'b1; ub_idx_d = t_q; ub_dt_d = head_i.dirty;
        end
        if (unref && after && !ra_f_q) begin
          ra_f_d = 1'b1; ra_idx_d = t_q; ra_dt_d = head_i.dirty;
        end
        if (unref && !after && !rb_f_q) begin
          rb_f_d = 1'b1; rb_idx_d = t_q; rb_dt_d = head_i.dirty;
        end
        t_d = last ? '0 : t_q + FW'(1);
        if (last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (fr_f_q) begin
          res_frame_d = pfvs_pkg::FRAME_W'(fr_idx_q);
          res_stat_d  = pfvs_pkg::STAT_FREE;
          res_mem_d   = 1'b0;
          state_d     = ST_DONE;
        end else if (!(ua_f_q || ub_f_q)) begin
          res_frame_d = '0;
          res_stat_d  = pfvs_pkg::STAT_NONE;
          res_mem_d   = 1'b0;
          state_d     = ST_DONE;
        end else begin
          vic_d       = pick_idx;
          res_frame_d = pfvs_pkg::FRAME_W'(pick_idx);
          res_stat_d  = pick_dt ? pfvs_pkg::STAT_DIRTY : pfvs_pkg::STAT_CLEAN;
          res_mem_d   = 1'b1;
          clear_all_d = !use_r;
          state_d     = mode_q ? ST_PASS2 : ST_EVICT;
        end
      end
      ST_PASS2: begin
        ctl_o.shift   = 1'b1;
        ctl_o.clr_ref = unprot && (clear_all_q || in_rng);
        t_d = last ? '0 : t_q + FW'(1);
        if (last) begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        ctl_o.evict = 1'b1;
        if (mode_q) begin
          clock_hand_d = next_vic;
        end else begin
          fifo_hand_d = next_vic;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        ctl_o.done = out_free_i;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      t_q          <= '0;
      fifo_hand_q  <= '0;
      clock_hand_q <= '0;
      fr_f_q <= 1'b0;
      ua_f_q <= 1'b0;
      ub_f_q <= 1'b0;
      ra_f_q <= 1'b0;
      rb_f_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      t_q          <= t_d;
      fifo_hand_q  <= fifo_hand_d;
      clock_hand_q <= clock_hand_d;
      fr_f_q <= fr_f_d;
      ua_f_q <= ua_f_d;
      ub_f_q <= ub_f_d;
      ra_f_q <= ra_f_d;
      rb_f_q <= rb_f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hand_q      <= hand_d;
    mode_q      <= mode_d;
    clear_all_q <= clear_all_d;
    vic_q       <= vic_d;
    fr_idx_q    <= fr_idx_d;
    ua_idx_q <= ua_idx_d; ua_dt_q <= ua_dt_d;
    ub_idx_q <= ub_idx_d; ub_dt_q <= ub_dt_d;
    ra_idx_q <= ra_idx_d; ra_dt_q <= ra_dt_d;
    rb_idx_q <= rb_idx_d; rb_dt_q <= rb_dt_d;
    res_frame_q <= res_frame_d;
    res_stat_q  <= res_stat_d;
    res_mem_q   <= res_mem_d;
  end

  assign victim_o = vic_q;

`ifndef NO_ASSERTIONS
  a_hands_move_on_evict_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EVICT) |=> ($stable(fifo_hand_q) && $stable(clock_hand_q)))
    else $error("A hand moved outside an eviction.");

  a_lap_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DECIDE || state_q == ST_EVICT) |-> (t_q == '0))
    else $error("The ring did not make a whole lap.");

  a_free_skips_eviction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && fr_f_q) |=> (state_q == ST_DONE))
    else $error("A free frame led to an eviction.");

  a_fifo_no_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && !mode_q) |=> (state_q != ST_PASS2))
    else $error("FIFO policy entered the clearing lap.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/page_frame_victim_selector_core.sv =====
// Top level of the page frame victim selector: frame ring, tag and owner memory,
// configuration port and result register. Depends on pfvs_pkg, pfvs_if, pfvs_cell and pfvs_scan.
//
//   Port      Direction  Handshake          Carries
//   req_i     in         valid / ready      kind, frame_index, page_tag, owner_id, flags
//   rsp_o     out        valid / ready      victim_frame, status, evicted_tag, evicted_owner
//   p*        in / out   psel, penable      policy_mode register at byte address 0
//
// Map, access and protection requests update the addressed cell directly. A victim request
// occupies the block from its accept cycle through one lap of the frame ring past its head
// cell and a decision when a free frame exists or none qualifies; a FIFO eviction adds an
// eviction step, and a clock eviction adds a second, reference-clearing lap before it.
// A result not yet taken holds the next finished search in its last cycle, and no request is
// accepted meanwhile. Reset clears the frame bits and hands at once; no clearing pass.
`default_nettype none

module page_frame_victim_selector_core #(
  parameter int unsigned FRAME_COUNT = 256,
  localparam int unsigned FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  pfvs_req_if.sink                           req_i,
  pfvs_rsp_if.source                         rsp_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [pfvs_pkg::ADDR_W-1:0]        paddr,
  input  wire  [pfvs_pkg::DATA_W-1:0]        pwdata,
  output logic [pfvs_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int unsigned MEM_W = pfvs_pkg::TAG_W + pfvs_pkg::OWNER_W;

  logic                mode_q;
  logic                req_fire, in_range, item_we, mem_we;
  pfvs_pkg::cell_cmd_t cmd;
  logic [FW-1:0]       cmd_idx, item_idx, victim;
  pfvs_pkg::rec_t      recs [FRAME_COUNT];
  pfvs_pkg::rec_t      tail;
  pfvs_pkg::scan_out_t ctl;
  logic                out_free;

  logic [MEM_W-1:0]    mem [FRAME_COUNT];
  logic [MEM_W-1:0]    rd_q;

  logic                            rsp_valid_q;
  logic [pfvs_pkg::FRAME_W-1:0]    rsp_frame_q;
  logic [pfvs_pkg::STAT_W-1:0]     rsp_stat_q;
  logic [pfvs_pkg::TAG_W-1:0]      rsp_tag_q;
  logic [pfvs_pkg::OWNER_W-1:0]    rsp_owner_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pfvs_pkg::REG_POLICY) ? {{(pfvs_pkg::DATA_W-1){1'b0}}, mode_q}
                                                     : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == pfvs_pkg::REG_POLICY)) begin
      mode_q <= pwdata[0];
    end
  end

  // Request decode.
  assign req_i.ready = ctl.ready;
  assign req_fire    = req_i.valid && ctl.ready;
  assign in_range    = (32'(req_i.frame_index) < 32'(FRAME_COUNT));
  assign item_idx    = FW'(req_i.frame_index);
  assign item_we     = req_fire && in_range && (req_i.kind != pfvs_pkg::KIND_VICTIM);
  assign mem_we      = item_we && (req_i.kind == pfvs_pkg::KIND_MAP);

  always_comb begin
    cmd           = '0;
    cmd.shift     = ctl.shift;
    cmd.wr_access = req_i.write_access;
    cmd.protect   = req_i.protect_flag;
    cmd_idx       = item_idx;
    if (ctl.evict) begin
      cmd.we  = 1'b1;
      cmd.op  = pfvs_pkg::OP_EVICT;
      cmd_idx = victim;
    end else if (item_we) begin
      cmd.we = 1'b1;
      unique case (req_i.kind)
        pfvs_pkg::KIND_MAP:     cmd.op = pfvs_pkg::OP_MAP;
        pfvs_pkg::KIND_ACCESS:  cmd.op = pfvs_pkg::OP_ACCESS;
        pfvs_pkg::KIND_PROTECT: cmd.op = pfvs_pkg::OP_PROTECT;
        default:                cmd.op = pfvs_pkg::OP_NONE;
      endcase
    end
  end

  // Frame ring: each cell hands its record to the one below, the head wraps to the tail.
  always_comb begin
    tail      = recs[0];
    tail.refd = recs[0].refd && !ctl.clr_ref;
  end

  for (genvar k = 0; k < FRAME_COUNT; k++) begin : g_cell
    pfvs_pkg::rec_t nb;
    if (k == FRAME_COUNT - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_body
      assign nb = recs[k+1];
    end
    pfvs_cell #(
      .IDX_W (FW),
      .IDX   (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .idx_i  (cmd_idx),
      .nb_i   (nb),
      .rec_o  (recs[k])
    );
  end

  pfvs_scan #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_fire && (req_i.kind == pfvs_pkg::KIND_VICTIM)),
    .mode_i     (mode_q),
    .head_i     (recs[0]),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .victim_o   (victim)
  );

  // Tag and owner memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[item_idx] <= {req_i.page_tag, req_i.owner_id};
    end
    rd_q <= mem[victim];
  end

  // Result register.
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctl.done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.done) begin
      rsp_frame_q <= ctl.frame;
      rsp_stat_q  <= ctl.status;
      rsp_tag_q   <= ctl.use_mem ? rd_q[MEM_W-1:pfvs_pkg::OWNER_W] : '0;
      rsp_owner_q <= ctl.use_mem ? rd_q[pfvs_pkg::OWNER_W-1:0] : '0;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.victim_frame  = rsp_frame_q;
  assign rsp_o.status        = rsp_stat_q;
  assign rsp_o.evicted_tag   = rsp_tag_q;
  assign rsp_o.evicted_owner = rsp_owner_q;

`ifndef NO_ASSERTIONS
  a_done_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.done |-> out_free)
    else $error("A result was loaded over one not yet taken.");

  a_no_write_while_shifting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift |-> !cmd.we)
    else $error("A cell update coincided with a ring shift.");

  a_busy_refuses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.shift || ctl.evict) |-> !req_i.ready)
    else $error("A request was offered ready during a search.");
`endif

endmodule

`default_nettype wire
